// ===== hw/rtl/framed_sensor_message_parser_defines.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the framed sensor message parser.
// Define NO_ASSERTIONS to compile the checks out.
// ---------------------------------------------------------------------------
`ifndef FRAMED_SENSOR_MESSAGE_PARSER_DEFINES_SVH
`define FRAMED_SENSOR_MESSAGE_PARSER_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Checked on every clock edge while the block is out of reset.
`define FSMP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("fsmp assertion failed");
// Checked on every clock edge, reset included.
`define FSMP_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("fsmp assertion failed");
`else
`define FSMP_ASSERT(lbl, prop)
`define FSMP_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

// ===== hw/rtl/fsmp_pkg.sv =====
// ---------------------------------------------------------------------------
// fsmp_pkg
// Types and constants shared by the framed sensor message parser modules.
// ---------------------------------------------------------------------------
package fsmp_pkg;

  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 17;
  localparam int unsigned TDATA_W    = 64;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_START_BYTE = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_END_BYTE   = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_END_RUN    = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SLOT_BASE  = 4'd3;

  localparam logic [7:0] START_BYTE_RST = 8'd170;
  localparam logic [7:0] END_BYTE_RST   = 8'd85;
  localparam logic [3:0] END_RUN_RST    = 4'd2;

  // Fields of a sensor slot register.
  localparam int unsigned SLOT_EN_BIT = 16;

  typedef logic [CFG_DATA_W-1:0] slot_t;

  typedef struct packed {
    logic [7:0] start_byte;
    logic [7:0] end_byte;
    logic [3:0] end_need;   // run length, zero already mapped to one
  } fsmp_cfg_t;

  typedef enum logic [2:0] {
    ST_BUSY    = 3'd0,
    ST_DATA    = 3'd1,
    ST_COMMIT  = 3'd2,
    ST_SUM_BAD = 3'd3,
    ST_HDR_BAD = 3'd4,
    ST_IGNORED = 3'd5
  } status_e;

  typedef enum logic [4:0] {
    PH_HUNT     = 5'b00001,
    PH_HEADER   = 5'b00010,
    PH_DATA     = 5'b00100,
    PH_END_OK   = 5'b01000,
    PH_END_FAIL = 5'b10000
  } phase_e;

  typedef enum logic [1:0] {
    HDR_ID  = 2'd0,
    HDR_LEN = 2'd1,
    HDR_SUM = 2'd2
  } hdr_pos_e;

endpackage

// ===== hw/rtl/framed_sensor_message_parser.sv =====
// ---------------------------------------------------------------------------
// framed_sensor_message_parser
// Parses start-byte framed sensor messages from a received byte stream.
// ---------------------------------------------------------------------------
// Usage: each byte on the slave stream produces exactly one result on the
// master stream. The result carries the status code in m_axis_tuser and the
// payload byte, its index, the matched slot, the frame length and the two
// saturating frame counters in m_axis_tdata.
// Configuration is written through the cfg channel (index 0 start byte,
// 1 end byte, 2 end-run length, 3 and up the sensor slots); the user must
// write it only while the stream is idle, which the block does not enforce.
// cfg_ready_o is always high. Each accepted byte's result is registered.
// Throughput is one byte per cycle while results are taken, set by the single
// parser state update between the input and the result register.
// When the receiver stalls, the result holds and the slave side accepts one
// more byte only once the held result is taken in the same cycle.
// Reset returns the parser to hunting for a start byte, clears both frame
// counters and loads the configuration defaults (start 170, end 85, run 2,
// all slots disabled).
// ---------------------------------------------------------------------------
`include "framed_sensor_message_parser_defines.svh"

module framed_sensor_message_parser #(
  parameter int unsigned SLOT_COUNT  = 4,
  parameter int unsigned MAX_PAYLOAD = 254
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Received byte stream. tdata: rx_byte[7:0].
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [7:0]                       s_axis_tdata,
  // Result stream. tuser: status[2:0].
  // tdata: data_byte[7:0], byte_index[15:8], slot_index[17:16],
  //        frame_length[25:18], good_frames[41:26], bad_frames[57:42], zeros.
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [fsmp_pkg::TDATA_W-1:0]     m_axis_tdata,
  output logic [2:0]                       m_axis_tuser,
  // Configuration write channel.
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [fsmp_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [fsmp_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import fsmp_pkg::*;

  localparam int unsigned SlotW  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam logic [7:0]  MaxLen = 8'(MAX_PAYLOAD);

  fsmp_cfg_t              cfg;
  slot_t [SLOT_COUNT-1:0] slots;

  assign cfg_ready_o = 1'b1;

  fsmp_cfg_regs #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg),
    .slots_o    (slots)
  );

  // Parser state.
  phase_e             phase_q, phase_d;
  hdr_pos_e           hpos_q, hpos_d;
  logic [7:0]         frame_id_q, frame_id_d;
  logic [7:0]         frame_len_q, frame_len_d;
  logic [7:0]         exp_sum_q, exp_sum_d;
  logic [7:0]         run_sum_q, run_sum_d;
  logic [7:0]         pay_cnt_q, pay_cnt_d;
  logic [3:0]         end_run_q, end_run_d;
  logic [SlotW-1:0]   slot_q, slot_d;
  logic [15:0]        good_q, good_d;
  logic [15:0]        bad_q, bad_d;

  // Result register.
  logic               out_valid_q;
  status_e            out_status_q;
  logic [7:0]         out_data_q;
  logic [7:0]         out_idx_q;
  logic [1:0]         out_slot_q;
  logic [7:0]         out_len_q;
  logic [15:0]        out_good_q;
  logic [15:0]        out_bad_q;

  status_e            status;
  logic [7:0]         dbyte;
  logic [7:0]         didx;
  logic               acc;
  logic [7:0]         rx;

  // Header lookup on the stored id and length.
  logic               hdr_found;
  logic               hdr_ok;
  logic [SlotW-1:0]   hdr_slot;
  logic [SlotW+1:0]   slot_ext;

  logic [3:0]         run_next;
  logic [7:0]         pay_inc;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign acc           = s_axis_tvalid && s_axis_tready;
  assign rx            = s_axis_tdata;

  always_comb begin
    hdr_found = 1'b0;
    hdr_ok    = 1'b0;
    hdr_slot  = '0;
    for (int s = 0; s < SLOT_COUNT; s++) begin
      if (!hdr_found && slots[s][SLOT_EN_BIT] && (slots[s][7:0] == frame_id_q)) begin
        hdr_found = 1'b1;
        hdr_slot  = SlotW'(s);
        hdr_ok    = (slots[s][15:8] == frame_len_q);
      end
    end
    if (frame_len_q > MaxLen) begin
      hdr_ok = 1'b0;
    end
  end

  assign pay_inc = pay_cnt_q + 8'd1;

  always_comb begin
    phase_d     = phase_q;
    hpos_d      = hpos_q;
    frame_id_d  = frame_id_q;
    frame_len_d = frame_len_q;
    exp_sum_d   = exp_sum_q;
    run_sum_d   = run_sum_q;
    pay_cnt_d   = pay_cnt_q;
    end_run_d   = end_run_q;
    slot_d      = slot_q;
    good_d      = good_q;
    bad_d       = bad_q;
    status      = ST_BUSY;
    dbyte       = 8'd0;
    didx        = 8'd0;
    run_next    = 4'd0;

    case (phase_q)
      PH_HUNT: begin
        if (rx == cfg.start_byte) begin
          phase_d = PH_HEADER;
          hpos_d  = HDR_ID;
        end else begin
          status = ST_IGNORED;
        end
      end
      PH_HEADER: begin
        case (hpos_q)
          HDR_ID: begin
            frame_id_d = rx;
            hpos_d     = HDR_LEN;
          end
          HDR_LEN: begin
            frame_len_d = rx;
            hpos_d      = HDR_SUM;
          end
          default: begin
            exp_sum_d = rx;
            hpos_d    = HDR_ID;
            end_run_d = 4'd0;
            pay_cnt_d = 8'd0;
            run_sum_d = frame_len_q;
            if (hdr_ok) begin
              slot_d  = hdr_slot;
              phase_d = (frame_len_q == 8'd0) ? PH_END_OK : PH_DATA;
            end else begin
              slot_d  = '0;
              status  = ST_HDR_BAD;
              phase_d = PH_END_FAIL;
              if (bad_q != 16'hFFFF) begin
                bad_d = bad_q + 16'd1;
              end
            end
          end
        endcase
      end
      PH_DATA: begin
        status    = ST_DATA;
        dbyte     = rx;
        didx      = pay_cnt_q;
        run_sum_d = run_sum_q + rx;
        pay_cnt_d = pay_inc;
        if (pay_inc >= frame_len_q) begin
          phase_d   = PH_END_OK;
          end_run_d = 4'd0;
        end
      end
      PH_END_OK, PH_END_FAIL: begin
        if (rx == cfg.end_byte) begin
          run_next = (end_run_q == 4'hF) ? 4'hF : end_run_q + 4'd1;
        end
        end_run_d = run_next;
        if (run_next == cfg.end_need) begin
          if (phase_q == PH_END_OK) begin
            if (run_sum_q == exp_sum_q) begin
              status = ST_COMMIT;
              if (good_q != 16'hFFFF) begin
                good_d = good_q + 16'd1;
              end
            end else begin
              status = ST_SUM_BAD;
              if (bad_q != 16'hFFFF) begin
                bad_d = bad_q + 16'd1;
              end
            end
          end
          phase_d   = PH_HUNT;
          end_run_d = 4'd0;
          hpos_d    = HDR_ID;
          pay_cnt_d = 8'd0;
        end
      end
      default: begin
        phase_d = PH_HUNT;
      end
    endcase
  end

  assign slot_ext = {2'b00, slot_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HUNT;
      hpos_q      <= HDR_ID;
      frame_id_q  <= '0;
      frame_len_q <= '0;
      exp_sum_q   <= '0;
      run_sum_q   <= '0;
      pay_cnt_q   <= '0;
      end_run_q   <= '0;
      slot_q      <= '0;
      good_q      <= '0;
      bad_q       <= '0;
    end else if (acc) begin
      phase_q     <= phase_d;
      hpos_q      <= hpos_d;
      frame_id_q  <= frame_id_d;
      frame_len_q <= frame_len_d;
      exp_sum_q   <= exp_sum_d;
      run_sum_q   <= run_sum_d;
      pay_cnt_q   <= pay_cnt_d;
      end_run_q   <= end_run_d;
      slot_q      <= slot_d;
      good_q      <= good_d;
      bad_q       <= bad_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (acc) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      out_status_q <= status;
      out_data_q   <= dbyte;
      out_idx_q    <= didx;
      out_slot_q   <= slot_ext[1:0];
      out_len_q    <= frame_len_d;
      out_good_q   <= good_d;
      out_bad_q    <= bad_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tdata  = {6'd0, out_bad_q, out_good_q, out_len_q, out_slot_q,
                          out_idx_q, out_data_q};

  // A payload byte always leaves as a data result in the next cycle.
  `FSMP_ASSERT(a_data_result, (acc && phase_q == PH_DATA) |=> (out_valid_q && out_status_q == ST_DATA))
  // The reject counter only moves on a header or checksum reject.
  `FSMP_ASSERT(a_bad_only_on_reject, (acc && status != ST_HDR_BAD && status != ST_SUM_BAD) |=> $stable(bad_q))
  // The commit counter never decreases.
  `FSMP_ASSERT(a_good_monotonic, 1'b1 |=> (good_q >= $past(good_q)))
  // Input back-pressure only comes from a held result that is not taken.
  `FSMP_ASSERT_ALWAYS(a_ready_cause, !s_axis_tready |-> (out_valid_q && !m_axis_tready))

endmodule

// ===== hw/rtl/fsmp_cfg_regs.sv =====
// ---------------------------------------------------------------------------
// fsmp_cfg_regs
// Configuration register file: framing bytes, end-run length and the
// sensor slot table.
// ---------------------------------------------------------------------------
module fsmp_cfg_regs #(
  parameter int unsigned SLOT_COUNT = 4
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   wr_en_i,
  input  logic [fsmp_pkg::CFG_IDX_W-1:0]         wr_index_i,
  input  logic [fsmp_pkg::CFG_DATA_W-1:0]        wr_data_i,
  output fsmp_pkg::fsmp_cfg_t                    cfg_o,
  output fsmp_pkg::slot_t [SLOT_COUNT-1:0]       slots_o
);
  import fsmp_pkg::*;

  logic [7:0]                 start_byte_q;
  logic [7:0]                 end_byte_q;
  logic [3:0]                 end_run_q;
  slot_t [SLOT_COUNT-1:0]     slots_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_byte_q <= START_BYTE_RST;
      end_byte_q   <= END_BYTE_RST;
      end_run_q    <= END_RUN_RST;
      slots_q      <= '0;
    end else if (wr_en_i) begin
      if (wr_index_i == REG_START_BYTE) begin
        start_byte_q <= wr_data_i[7:0];
      end
      if (wr_index_i == REG_END_BYTE) begin
        end_byte_q <= wr_data_i[7:0];
      end
      if (wr_index_i == REG_END_RUN) begin
        end_run_q <= wr_data_i[3:0];
      end
      for (int s = 0; s < SLOT_COUNT; s++) begin
        if (wr_index_i == CFG_IDX_W'(int'(REG_SLOT_BASE) + s)) begin
          slots_q[s] <= wr_data_i;
        end
      end
    end
  end

  always_comb begin
    cfg_o.start_byte = start_byte_q;
    cfg_o.end_byte   = end_byte_q;
    cfg_o.end_need   = (end_run_q == 4'd0) ? 4'd1 : end_run_q;
  end

  assign slots_o = slots_q;

endmodule

// ===== tb/sv/tb_framed_sensor_message_parser.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_framed_sensor_message_parser
// Streams received bytes into the parser under random sender bursts and
// receiver stalls, predicts every result with a cycle-free parser model kept
// in the bench, and compares each result field against that prediction.
// Several framing setups are programmed between traffic phases.
// ---------------------------------------------------------------------------
module tb_framed_sensor_message_parser;
  import fsmp_pkg::*;

  localparam int unsigned SLOT_COUNT     = 4;
  localparam int unsigned MAX_PAYLOAD    = 254;
  localparam int          WATCHDOG_LIMIT = 3000;
  localparam int          LONG_HOLD      = 300;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 4'd15;

  typedef struct packed {
    status_e     status;
    logic [7:0]  data_byte;
    logic [7:0]  byte_index;
    logic [1:0]  slot_index;
    logic [7:0]  frame_length;
    logic [15:0] good_frames;
    logic [15:0] bad_frames;
  } frame_report_t;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [7:0]            s_axis_tdata  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [TDATA_W-1:0]    m_axis_tdata;
  logic [2:0]            m_axis_tuser;
  logic                  cfg_valid_i   = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;

  // Bench copy of the framing setup, updated on each accepted register write.
  logic [7:0] set_start = START_BYTE_RST;
  logic [7:0] set_end   = END_BYTE_RST;
  logic [3:0] set_run   = END_RUN_RST;
  slot_t      slot_cfg [SLOT_COUNT] = '{default: '0};
  slot_t      plan_slots [SLOT_COUNT];

  // Parser state of the bench model.
  phase_e      rx_phase    = PH_HUNT;
  hdr_pos_e    hdr_pos     = HDR_ID;
  logic [7:0]  frm_id      = '0;
  logic [7:0]  frm_len     = '0;
  logic [7:0]  hdr_sum     = '0;
  logic [7:0]  run_sum     = '0;
  logic [7:0]  payload_cnt = '0;
  logic [3:0]  end_cnt     = '0;
  logic [1:0]  match_slot  = '0;
  logic [15:0] good_cnt    = '0;
  logic [15:0] bad_cnt     = '0;

  logic [7:0]    rx_bytes_q[$];
  frame_report_t frame_reports_q[$];

  int          burst_left = 1;
  int          idle_gap   = 0;
  int          taken_cnt  = 0;
  int          hold_left  = 0;
  logic [7:0]  stall_mask = 8'hFF;
  logic [5:0]  mask_age   = '0;
  int unsigned mismatch_count = 0;
  int          quiet_cycles   = 0;

  framed_sensor_message_parser #(
    .SLOT_COUNT  (SLOT_COUNT),
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Advances the bench parser by one received byte and returns its result.
  function automatic frame_report_t parse_rx_byte(input logic [7:0] b);
    frame_report_t r;
    logic [3:0]    need;
    bit            found;
    bit            hdr_ok;
    int            s;
    r = '0;
    r.status = ST_BUSY;
    case (rx_phase)
      PH_HUNT: begin
        if (b == set_start) begin
          rx_phase = PH_HEADER;
          hdr_pos = HDR_ID;
        end else begin
          r.status = ST_IGNORED;
        end
      end
      PH_HEADER: begin
        if (hdr_pos == HDR_ID) begin
          frm_id = b;
          hdr_pos = HDR_LEN;
        end else if (hdr_pos == HDR_LEN) begin
          frm_len = b;
          hdr_pos = HDR_SUM;
        end else begin
          hdr_sum = b;
          hdr_pos = HDR_ID;
          end_cnt = '0;
          payload_cnt = '0;
          run_sum = frm_len;
          // Only the lowest enabled slot with this id decides; its length must match.
          match_slot = '0;
          found = 1'b0;
          hdr_ok = 1'b0;
          if (frm_len <= MAX_PAYLOAD) begin
            for (s = 0; s < SLOT_COUNT; s++) begin
              if (!found && slot_cfg[s][SLOT_EN_BIT] && slot_cfg[s][7:0] == frm_id) begin
                found = 1'b1;
                if (slot_cfg[s][15:8] == frm_len) begin
                  hdr_ok = 1'b1;
                  match_slot = 2'(s);
                end
              end
            end
          end
          if (hdr_ok) begin
            rx_phase = (frm_len == 8'd0) ? PH_END_OK : PH_DATA;
          end else begin
            r.status = ST_HDR_BAD;
            if (bad_cnt != 16'hFFFF) bad_cnt++;
            rx_phase = PH_END_FAIL;
          end
        end
      end
      PH_DATA: begin
        r.status = ST_DATA;
        r.data_byte = b;
        r.byte_index = payload_cnt;
        run_sum = run_sum + b;
        payload_cnt = payload_cnt + 8'd1;
        if (payload_cnt >= frm_len) begin
          rx_phase = PH_END_OK;
          end_cnt = '0;
        end
      end
      default: begin
        if (b == set_end) begin
          if (end_cnt != 4'd15) end_cnt++;
        end else begin
          end_cnt = '0;
        end
        need = (set_run == 4'd0) ? 4'd1 : set_run;
        if (end_cnt == need) begin
          if (rx_phase == PH_END_OK) begin
            if (run_sum == hdr_sum) begin
              r.status = ST_COMMIT;
              if (good_cnt != 16'hFFFF) good_cnt++;
            end else begin
              r.status = ST_SUM_BAD;
              if (bad_cnt != 16'hFFFF) bad_cnt++;
            end
          end
          rx_phase = PH_HUNT;
          end_cnt = '0;
          hdr_pos = HDR_ID;
          payload_cnt = '0;
        end
      end
    endcase
    r.slot_index = match_slot;
    r.frame_length = frm_len;
    r.good_frames = good_cnt;
    r.bad_frames = bad_cnt;
    return r;
  endfunction

  function automatic string report_text(input frame_report_t r);
    return $sformatf("status=%0d byte=%02h index=%0d slot=%0d len=%0d good=%0d bad=%0d",
                     r.status, r.data_byte, r.byte_index, r.slot_index, r.frame_length,
                     r.good_frames, r.bad_frames);
  endfunction

  // Queues one frame: start, id, length, checksum, payload, then the end run,
  // which is sometimes interrupted once before it completes.
  task automatic queue_frame(input logic [7:0] id, input logic [7:0] len, input bit sum_ok);
    logic [7:0] body[$];
    logic [7:0] sum;
    int         n;
    int         need;
    sum = len;
    n = (len > MAX_PAYLOAD) ? 3 : int'(len);
    repeat (n) begin
      body.push_back(8'($urandom));
      sum = sum + body[$];
    end
    if (!sum_ok) sum = sum + 8'($urandom_range(1, 255));
    rx_bytes_q.push_back(set_start);
    rx_bytes_q.push_back(id);
    rx_bytes_q.push_back(len);
    rx_bytes_q.push_back(sum);
    foreach (body[i]) rx_bytes_q.push_back(body[i]);
    need = (set_run == 4'd0) ? 1 : int'(set_run);
    if ($urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(0, need - 1)) rx_bytes_q.push_back(set_end);
      rx_bytes_q.push_back(set_end + 8'd1);
    end
    repeat (need) rx_bytes_q.push_back(set_end);
  endtask

  // Called at a clock edge; leaves cfg_valid_i high for a following write.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input slot_t val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == REG_START_BYTE) begin
      set_start = val[7:0];
    end else if (idx == REG_END_BYTE) begin
      set_end = val[7:0];
    end else if (idx == REG_END_RUN) begin
      set_run = val[3:0];
    end else if (idx >= REG_SLOT_BASE && idx < REG_SLOT_BASE + SLOT_COUNT) begin
      slot_cfg[2'(idx - REG_SLOT_BASE)] = val;
    end
  endtask

  task automatic program_setup(input logic [7:0] sb, input logic [7:0] eb,
                               input logic [3:0] run);
    write_reg(REG_START_BYTE, slot_t'(sb));
    write_reg(REG_END_BYTE, slot_t'(eb));
    write_reg(REG_END_RUN, slot_t'(run));
    for (int s = 0; s < SLOT_COUNT; s++) write_reg(REG_SLOT_BASE + 4'(s), plan_slots[s]);
    write_reg(REG_UNUSED, slot_t'($urandom));
    cfg_valid_i <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(posedge clk_i);
    while (rx_bytes_q.size() != 0 || s_axis_tvalid || frame_reports_q.size() != 0);
    repeat (2) @(posedge clk_i);
  endtask

  // Sender: bursts of random length separated by random gaps, some gapless.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      burst_left <= 1;
      idle_gap <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        frame_reports_q.push_back(parse_rx_byte(s_axis_tdata));
        void'(rx_bytes_q.pop_front());
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (idle_gap != 0) begin
          idle_gap <= idle_gap - 1;
          s_axis_tvalid <= 1'b0;
        end else if (rx_bytes_q.size() != 0) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= rx_bytes_q[0];
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 48);
            idle_gap <= ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 10);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: a rotating stall mask, renewed each time its age counter wraps,
  // plus two long hold-offs during which the parser must stop taking bytes.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      taken_cnt <= 0;
      hold_left <= 0;
      stall_mask <= 8'hFF;
      mask_age <= '0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) taken_cnt <= taken_cnt + 1;
      mask_age <= mask_age + 6'd1;
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        m_axis_tready <= 1'b0;
      end else if (m_axis_tvalid && m_axis_tready && (taken_cnt == 499 || taken_cnt == 1399)) begin
        hold_left <= LONG_HOLD;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= stall_mask[0];
        if (mask_age == 6'd63) begin
          stall_mask <= ($urandom_range(0, 2) == 0) ? 8'hFF : (8'($urandom) | 8'h01);
        end else begin
          stall_mask <= {stall_mask[0], stall_mask[7:1]};
        end
      end
    end
  end

  always @(posedge clk_i) begin
    frame_report_t got;
    frame_report_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.status       = status_e'(m_axis_tuser);
      got.data_byte    = m_axis_tdata[7:0];
      got.byte_index   = m_axis_tdata[15:8];
      got.slot_index   = m_axis_tdata[17:16];
      got.frame_length = m_axis_tdata[25:18];
      got.good_frames  = m_axis_tdata[41:26];
      got.bad_frames   = m_axis_tdata[57:42];
      if (frame_reports_q.size() == 0) begin
        if (mismatch_count < 10) $display("%0t: unexpected result %s", $time, report_text(got));
        mismatch_count <= mismatch_count + 1;
      end else begin
        want = frame_reports_q.pop_front();
        if (got !== want) begin
          if (mismatch_count < 10) begin
            $display("%0t: result mismatch\n  expected %s\n  actual   %s",
                     $time, report_text(want), report_text(got));
          end
          mismatch_count <= mismatch_count + 1;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [7:0] opening [8];
    logic [7:0] sb;
    logic [7:0] eb;
    logic [3:0] run;
    logic [7:0] id;
    logic [7:0] len;
    int         k;
    int         s;

    opening = '{8'h00, 8'hFF, START_BYTE_RST, 8'h00, 8'h00, 8'h00,
                END_BYTE_RST, END_BYTE_RST};

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset setup: bytes ignored while hunting, then a header that no slot
    // accepts because every slot is disabled.
    foreach (opening[i]) rx_bytes_q.push_back(opening[i]);
    wait_drained();

    // Slot 3 repeats the id of slot 0 with another length, so the lowest
    // slot must win; slot 1 takes zero-length frames.
    plan_slots[0] = {1'b1, 8'd3, 8'h10};
    plan_slots[1] = {1'b1, 8'd0, 8'h20};
    plan_slots[2] = {1'b0, 8'd5, 8'h30};
    plan_slots[3] = {1'b1, 8'd5, 8'h10};
    program_setup(8'h7E, 8'h81, 4'd2);
    queue_frame(8'h10, 8'd3, 1'b1);
    queue_frame(8'h20, 8'd0, 1'b1);
    queue_frame(8'h10, 8'd5, 1'b1);
    wait_drained();

    for (int p = 0; p < 6; p++) begin
      case (p)
        0: begin
          sb = 8'h00;
          eb = 8'hFF;
          run = 4'd1;
        end
        1: begin
          sb = 8'hFF;
          eb = 8'h00;
          run = 4'd15;
        end
        2: begin
          sb = 8'($urandom);
          eb = 8'($urandom);
          run = 4'd0;
        end
        default: begin
          sb = 8'($urandom);
          eb = 8'($urandom);
          run = 4'($urandom_range(1, 6));
        end
      endcase
      for (s = 0; s < SLOT_COUNT; s++) begin
        plan_slots[s] = {($urandom_range(0, 3) != 0), 8'($urandom_range(0, 9)), 8'($urandom)};
      end
      if (p == 3) plan_slots[3] = {1'b1, 8'(MAX_PAYLOAD), 8'($urandom)};
      program_setup(sb, eb, run);

      while (rx_bytes_q.size() < 290) begin
        k = $urandom_range(0, 99);
        s = $urandom_range(0, SLOT_COUNT - 1);
        id = slot_cfg[s][7:0];
        len = slot_cfg[s][15:8];
        if ($urandom_range(0, 3) == 0) begin
          repeat ($urandom_range(1, 3)) rx_bytes_q.push_back(8'($urandom));
        end
        if (k < 70) begin
          queue_frame(id, len, 1'b1);
        end else if (k < 80) begin
          queue_frame(id, len, 1'b0);
        end else if (k < 86) begin
          queue_frame(8'($urandom), len, 1'b1);
        end else if (k < 92) begin
          queue_frame(id, len + 8'($urandom_range(1, 3)), 1'b1);
        end else if (k < 95) begin
          queue_frame(id, 8'hFF, 1'b1);
        end else begin
          // Truncated frame: the header is cut short by whatever follows.
          rx_bytes_q.push_back(set_start);
          repeat ($urandom_range(1, 4)) rx_bytes_q.push_back(8'($urandom));
        end
      end
      wait_drained();
    end

    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0 && frame_reports_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
